/* hw/rtl/npcc_pkg.sv */
// ---------------------------------------------------------------------------
// Nearest palette color classifier package
// Shared types, constants and the candidate compare used by the core.
// ---------------------------------------------------------------------------
`default_nettype none

package npcc_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned ColorW   = 3 * ChanW;
  localparam int unsigned PairW    = 2 * ColorW;
  localparam int unsigned NumPairs = 4;
  localparam int unsigned NumW     = 4;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned SqW      = 2 * ChanW;
  localparam int unsigned DistW    = 18;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned TreeW    = 8;

  localparam logic [NumW-1:0]  NumReset = 4'd8;
  localparam logic [DistW-1:0] DistMax  = 18'd195075;

  typedef enum logic [RegIdxW-1:0] {
    REG_NUM_CLUSTERS = 3'd0,
    REG_PAIR_A       = 3'd1,
    REG_PAIR_B       = 3'd2,
    REG_PAIR_C       = 3'd3,
    REG_PAIR_D       = 3'd4
  } cfg_reg_e;

  // Per-stage advance strobes for the lane datapath.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } adv_t;

  typedef struct packed {
    logic             ok;
    logic [IdxW-1:0]  idx;
    logic [DistW-1:0] dist_sq;
  } cand_t;

  // Keep the left (lower index) candidate unless the right one is strictly closer.
  function automatic cand_t pick(input cand_t a, input cand_t b);
    cand_t r;
    r = a;
    if (b.ok && (!a.ok || (b.dist_sq < a.dist_sq))) begin
      r = b;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/npcc_lane.sv */
// ---------------------------------------------------------------------------
// Nearest palette color classifier distance lane
// Three-stage squared distance between the pixel and one palette color:
// absolute difference, square, channel sum.
// ---------------------------------------------------------------------------
`default_nettype none

module npcc_lane (
  input  wire                                       clk_i,
  input  wire npcc_pkg::adv_t                       adv_i,
  input  wire [2:0][npcc_pkg::ChanW-1:0]            px_i,
  input  wire [npcc_pkg::ColorW-1:0]                color_i,
  output logic [npcc_pkg::DistW-1:0]                dist_o
);

  logic [2:0][npcc_pkg::ChanW-1:0] diff_d, diff_q;
  logic [2:0][npcc_pkg::SqW-1:0]   sq_q;
  logic [npcc_pkg::DistW-1:0]      dist_d, dist_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (px_i[c] >= color_i[c*npcc_pkg::ChanW +: npcc_pkg::ChanW]) begin
        diff_d[c] = px_i[c] - color_i[c*npcc_pkg::ChanW +: npcc_pkg::ChanW];
      end else begin
        diff_d[c] = color_i[c*npcc_pkg::ChanW +: npcc_pkg::ChanW] - px_i[c];
      end
    end
  end

  assign dist_d = npcc_pkg::DistW'(sq_q[0]) + npcc_pkg::DistW'(sq_q[1])
                + npcc_pkg::DistW'(sq_q[2]);

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      diff_q <= diff_d;
    end
    if (adv_i.s2) begin
      for (int c = 0; c < 3; c++) begin
        sq_q[c] <= diff_q[c] * diff_q[c];
      end
    end
    if (adv_i.s3) begin
      dist_q <= dist_d;
    end
  end

  assign dist_o = dist_q;

endmodule

`default_nettype wire

/* hw/rtl/nearest_palette_color_classifier_core.sv */
// ---------------------------------------------------------------------------
// Nearest palette color classifier core
// Maps each pixel to the closest of up to eight configured palette colors.
// ---------------------------------------------------------------------------
// The core takes one pixel per clock while in_stall_o is low and returns the
// index of the nearest active palette color by squared Euclidean distance
// together with that distance; ties go to the lowest index. The five
// register stages are: channel difference, square, channel sum, first
// compare level (eight candidates to four) and final compare (four to one,
// held in the output register). Each stage advances whenever it is empty or
// the stage after it moves, so a stall on the output only backs up the
// items behind it and bubbles are squeezed out. A num_clusters of zero acts
// as one and a value above MAX_CLUSTERS acts as MAX_CLUSTERS. Write the
// configuration only while no item is in flight.
`default_nettype none

module nearest_palette_color_classifier_core #(
  parameter int unsigned MAX_CLUSTERS = 8
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire [npcc_pkg::RegIdxW-1:0]         cfg_index_i,
  input  wire [npcc_pkg::PairW-1:0]           cfg_data_i,
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire [npcc_pkg::ChanW-1:0]           chan_zero_i,
  input  wire [npcc_pkg::ChanW-1:0]           chan_one_i,
  input  wire [npcc_pkg::ChanW-1:0]           chan_two_i,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic [npcc_pkg::IdxW-1:0]           cluster_index_o,
  output logic [npcc_pkg::DistW-1:0]          min_dist_sq_o
);

  localparam int unsigned NumStg = 5;

  // Configuration registers
  logic [npcc_pkg::NumW-1:0]                     num_q;
  logic [npcc_pkg::NumPairs-1:0][npcc_pkg::PairW-1:0] pal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= npcc_pkg::NumReset;
      pal_q <= '0;
    end else if (cfg_we_i) begin
      case (npcc_pkg::cfg_reg_e'(cfg_index_i))
        npcc_pkg::REG_NUM_CLUSTERS: num_q    <= cfg_data_i[npcc_pkg::NumW-1:0];
        npcc_pkg::REG_PAIR_A:       pal_q[0] <= cfg_data_i;
        npcc_pkg::REG_PAIR_B:       pal_q[1] <= cfg_data_i;
        npcc_pkg::REG_PAIR_C:       pal_q[2] <= cfg_data_i;
        npcc_pkg::REG_PAIR_D:       pal_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Active color count, clamped to the lane range.
  logic [npcc_pkg::NumW-1:0] act_n;

  always_comb begin
    if (num_q == '0) begin
      act_n = npcc_pkg::NumW'(1);
    end else if (num_q > npcc_pkg::NumW'(MAX_CLUSTERS)) begin
      act_n = npcc_pkg::NumW'(MAX_CLUSTERS);
    end else begin
      act_n = num_q;
    end
  end

  // Valid chain and per-stage advance
  logic [NumStg-1:0] v_q;
  logic [NumStg-1:0] adv;
  logic              in_acc;

  always_comb begin
    adv[NumStg-1] = !v_q[NumStg-1] || !out_stall_i;
    for (int s = NumStg - 2; s >= 0; s--) begin
      adv[s] = !v_q[s] || adv[s+1];
    end
  end

  assign in_stall_o = !adv[0];
  assign in_acc     = in_valid_i && adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= in_acc;
      end
      for (int s = 1; s < NumStg; s++) begin
        if (adv[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  // Distance lanes, stages one to three
  npcc_pkg::adv_t                    lane_adv;
  logic [2:0][npcc_pkg::ChanW-1:0]   px;
  logic [MAX_CLUSTERS-1:0][npcc_pkg::DistW-1:0] lane_dist;

  assign lane_adv.s1 = adv[0];
  assign lane_adv.s2 = adv[1];
  assign lane_adv.s3 = adv[2];
  assign px          = {chan_two_i, chan_one_i, chan_zero_i};

  for (genvar k = 0; k < MAX_CLUSTERS; k++) begin : g_lane
    npcc_lane u_lane (
      .clk_i   (clk_i),
      .adv_i   (lane_adv),
      .px_i    (px),
      .color_i (pal_q[k/2][(k%2)*npcc_pkg::ColorW +: npcc_pkg::ColorW]),
      .dist_o  (lane_dist[k])
    );
  end

  // Candidates, padded to the full tree width with empty slots
  npcc_pkg::cand_t cand [npcc_pkg::TreeW];

  always_comb begin
    for (int k = 0; k < npcc_pkg::TreeW; k++) begin
      cand[k].ok      = 1'b0;
      cand[k].idx     = npcc_pkg::IdxW'(k);
      cand[k].dist_sq = '0;
    end
    for (int k = 0; k < MAX_CLUSTERS; k++) begin
      cand[k].ok      = (npcc_pkg::NumW'(k) < act_n);
      cand[k].dist_sq = lane_dist[k];
    end
  end

  // Stage four: pairwise compare; stage five: final compare into output
  npcc_pkg::cand_t c4_q [npcc_pkg::TreeW/2];
  npcc_pkg::cand_t out_q;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      for (int j = 0; j < npcc_pkg::TreeW / 2; j++) begin
        c4_q[j] <= npcc_pkg::pick(cand[2*j], cand[2*j+1]);
      end
    end
    if (adv[4]) begin
      out_q <= npcc_pkg::pick(npcc_pkg::pick(c4_q[0], c4_q[1]),
                              npcc_pkg::pick(c4_q[2], c4_q[3]));
    end
  end

  assign out_valid_o     = v_q[NumStg-1];
  assign cluster_index_o = out_q.idx;
  assign min_dist_sq_o   = out_q.dist_sq;

  // Assertions
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q))
    else $error("input stalled while the pipeline has a free stage");

  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (min_dist_sq_o <= npcc_pkg::DistMax))
    else $error("distance out of range");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (npcc_pkg::NumW'(cluster_index_o) < npcc_pkg::NumW'(MAX_CLUSTERS)))
    else $error("cluster index beyond the lane count");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_stall_i && !v_q[NumStg-2]) |=> !out_valid_o)
    else $error("output valid without an item from the previous stage");

endmodule

`default_nettype wire
